/* hdl/gcs_pkg.sv */
// shared constants, types and gait pattern tables for the contact scheduler
package gcs_pkg;

    localparam int STEPS = 16;
    localparam int IW    = $clog2(STEPS);
    localparam int PW    = $clog2(STEPS + 1);
    localparam int KW    = $clog2(STEPS + 2);
    localparam int GW    = $clog2(4 * STEPS + 1);
    localparam int CW    = $clog2(2 * STEPS + 3);
    localparam int REP2  = STEPS / 2;
    localparam int REP4  = STEPS / 4;

    localparam logic [2:0] GAIT_NONE   = 3'd0;
    localparam logic [2:0] GAIT_STATIC = 3'd1;

    typedef struct packed {
        logic capture;
        logic roll;
        logic scan_init;
        logic rem_step;
        logic des_step;
        logic el_init;
        logic el_step;
        logic past_step;
        logic out_load;
    } gcs_cmd_t;

    typedef struct packed {
        logic ff_needed;
        logic flag;
        logic guard_done;
        logic adv;
        logic rem_more;
        logic idx_last;
        logic des_more;
        logic el_more;
        logic idx_zero;
        logic past_more;
    } gcs_stat_t;

    function automatic logic [2:0] pat_count(input logic [2:0] code);
        case (code)
            3'd1:    pat_count = 3'd1;
            3'd2:    pat_count = 3'd4;
            3'd3:    pat_count = 3'd2;
            3'd4:    pat_count = 3'd2;
            3'd5:    pat_count = 3'd2;
            3'd6:    pat_count = 3'd4;
            3'd7:    pat_count = 3'd4;
            default: pat_count = 3'd0;
        endcase
    endfunction

    function automatic logic [3:0] pat_row(input logic [2:0] code, input logic [1:0] p);
        case ({code, p})
            5'b001_00: pat_row = 4'hF;
            5'b010_00: pat_row = 4'hE;
            5'b010_01: pat_row = 4'hD;
            5'b010_10: pat_row = 4'hB;
            5'b010_11: pat_row = 4'h7;
            5'b011_00: pat_row = 4'h9;
            5'b011_01: pat_row = 4'h6;
            5'b100_00: pat_row = 4'h5;
            5'b100_01: pat_row = 4'hA;
            5'b101_00: pat_row = 4'h3;
            5'b101_01: pat_row = 4'hC;
            5'b110_00: pat_row = 4'h9;
            5'b110_01: pat_row = 4'hF;
            5'b110_10: pat_row = 4'h6;
            5'b110_11: pat_row = 4'hF;
            5'b111_00: pat_row = 4'h5;
            5'b111_01: pat_row = 4'h9;
            5'b111_10: pat_row = 4'hA;
            5'b111_11: pat_row = 4'h6;
            default:   pat_row = 4'h0;
        endcase
    endfunction

endpackage

/* hdl/gcs_ctrl.sv */
// sequencing state machine for rolls and phase scans
module gcs_ctrl import gcs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  gcs_stat_t stat,
    output gcs_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_FF   = 10'b0000000010,
        S_ADV  = 10'b0000000100,
        S_INIT = 10'b0000001000,
        S_REM  = 10'b0000010000,
        S_DES  = 10'b0000100000,
        S_ELI  = 10'b0001000000,
        S_ELP  = 10'b0010000000,
        S_PST  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_FF;
                end
            end
            S_FF: begin
                if (stat.ff_needed && !stat.flag && !stat.guard_done) begin
                    cmd.roll = 1'b1;
                end else begin
                    state_next = S_ADV;
                end
            end
            S_ADV: begin
                cmd.roll   = stat.adv;
                state_next = S_INIT;
            end
            S_INIT: begin
                cmd.scan_init = 1'b1;
                state_next    = S_REM;
            end
            S_REM: begin
                if (stat.rem_more) begin
                    cmd.rem_step = 1'b1;
                end else if (stat.idx_last) begin
                    state_next = S_DES;
                end else begin
                    state_next = S_ELI;
                end
            end
            S_DES: begin
                if (stat.des_more) begin
                    cmd.des_step = 1'b1;
                end else begin
                    state_next = S_ELI;
                end
            end
            S_ELI: begin
                cmd.el_init = 1'b1;
                state_next  = S_ELP;
            end
            S_ELP: begin
                if (stat.el_more) begin
                    cmd.el_step = 1'b1;
                end else if (stat.idx_zero) begin
                    state_next = S_PST;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_PST: begin
                if (stat.past_more) begin
                    cmd.past_step = 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

/* hdl/gcs_dp.sv */
// contact tables, roll logic, scan counters and result register
module gcs_dp import gcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_tdata,
    output logic [23:0] m_tdata,
    input  gcs_cmd_t    cmd,
    output gcs_stat_t   stat
);

    logic [3:0]    past_reg [STEPS+1];
    logic [3:0]    cur_reg  [STEPS];
    logic [3:0]    des_reg  [STEPS];
    logic [3:0]    cur_roll [STEPS];
    logic [3:0]    des_roll [STEPS];
    logic [3:0]    des_load [STEPS];
    logic [2:0]    gait_reg;
    logic          flag_reg, ff_reg, adv_reg, st_reg;
    logic [IW-1:0] row_reg, idx_reg, idx_p1, idx_m1;
    logic [1:0]    leg_reg;
    logic [KW-1:0] k_reg;
    logic [GW-1:0] guard_reg;
    logic [CW-1:0] rem_reg, el_reg;
    logic [CW:0]   tot;
    logic [23:0]   out_reg;
    logic [2:0]    tgt;
    logic [3:0]    qrow;
    logic [IW-1:0] row_clamp;
    logic          live_c, live_d, gchg;

    assign tgt    = s_tdata[2:0];
    assign qrow   = s_tdata[7:4];
    assign gchg   = (tgt != GAIT_NONE) && (tgt != gait_reg);
    assign idx_p1 = idx_reg + 1'b1;
    assign idx_m1 = idx_reg - 1'b1;
    assign row_clamp = (int'(qrow) >= STEPS) ? IW'(STEPS - 1) : IW'(qrow);

    always_comb begin
        live_c = 1'b1;
        live_d = 1'b1;
        for (int j = 0; j < STEPS; j++) begin
            if (j < STEPS - 1 && live_c && cur_reg[j+1] != 4'h0) begin
                cur_roll[j] = cur_reg[j+1];
            end else if (live_c) begin
                cur_roll[j] = des_reg[0];
                live_c      = 1'b0;
            end else begin
                cur_roll[j] = cur_reg[j];
            end
            if (j < STEPS - 1 && live_d && des_reg[j+1] != 4'h0) begin
                des_roll[j] = des_reg[j+1];
            end else if (live_d) begin
                des_roll[j] = des_reg[0];
                live_d      = 1'b0;
            end else begin
                des_roll[j] = des_reg[j];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < STEPS; i++) begin
            case (pat_count(tgt))
                3'd1:    des_load[i] = pat_row(tgt, 2'd0);
                3'd2:    des_load[i] = (i < 2 * REP2) ? pat_row(tgt, 2'(i / REP2)) : 4'h0;
                3'd4:    des_load[i] = (i < 4 * REP4) ? pat_row(tgt, 2'(i / REP4)) : 4'h0;
                default: des_load[i] = 4'h0;
            endcase
        end
    end

    always_comb begin
        stat            = '0;
        stat.ff_needed  = ff_reg;
        stat.flag       = flag_reg;
        stat.guard_done = (int'(guard_reg) >= 4 * STEPS);
        stat.adv        = adv_reg;
        stat.idx_last   = (int'(idx_reg) == STEPS - 1);
        stat.idx_zero   = (idx_reg == '0);
        stat.rem_more   = !stat.idx_last && (cur_reg[idx_p1][leg_reg] == st_reg);
        stat.des_more   = (int'(k_reg) < STEPS) && (des_reg[k_reg[IW-1:0]][leg_reg] == st_reg);
        stat.el_more    = !stat.idx_zero && (cur_reg[idx_m1][leg_reg] == st_reg);
        stat.past_more  = (int'(k_reg) < STEPS + 1) && (past_reg[k_reg[PW-1:0]] != 4'h0)
                          && (past_reg[k_reg[PW-1:0]][leg_reg] == st_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STEPS + 1; i++) past_reg[i] <= 4'h0;
            for (int i = 0; i < STEPS; i++) begin
                cur_reg[i] <= 4'hF;
                des_reg[i] <= 4'hF;
            end
            gait_reg <= GAIT_NONE;
            flag_reg <= 1'b0;
            ff_reg   <= 1'b0;
        end else begin
            if (cmd.capture) begin
                ff_reg <= gchg && (gait_reg == GAIT_STATIC) && (tgt != GAIT_STATIC);
                if (gchg) begin
                    des_reg  <= des_load;
                    gait_reg <= tgt;
                end
            end
            if (cmd.roll) begin
                for (int m = 1; m < STEPS + 1; m++) past_reg[m] <= past_reg[m-1];
                past_reg[0] <= cur_reg[0];
                flag_reg    <= (cur_reg[0] != cur_reg[1]);
                cur_reg     <= cur_roll;
                des_reg     <= des_roll;
            end
        end
    end

    assign tot = {1'b0, el_reg} + {1'b0, rem_reg};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            adv_reg   <= s_tdata[3];
            row_reg   <= row_clamp;
            leg_reg   <= s_tdata[9:8];
            guard_reg <= '0;
        end
        if (cmd.roll) guard_reg <= guard_reg + 1'b1;
        if (cmd.scan_init) begin
            st_reg  <= cur_reg[row_reg][leg_reg];
            idx_reg <= row_reg;
            rem_reg <= CW'(1);
            el_reg  <= '0;
            k_reg   <= '0;
        end
        if (cmd.rem_step) begin
            idx_reg <= idx_p1;
            rem_reg <= rem_reg + 1'b1;
        end
        if (cmd.des_step) begin
            k_reg   <= k_reg + 1'b1;
            rem_reg <= rem_reg + 1'b1;
        end
        if (cmd.el_init) begin
            idx_reg <= row_reg;
            k_reg   <= '0;
        end
        if (cmd.el_step) begin
            idx_reg <= idx_m1;
            el_reg  <= el_reg + 1'b1;
        end
        if (cmd.past_step) begin
            k_reg  <= k_reg + 1'b1;
            el_reg <= el_reg + 1'b1;
        end
        if (cmd.out_load) begin
            out_reg[0]     <= flag_reg;
            out_reg[1]     <= st_reg;
            out_reg[7:2]   <= (int'(el_reg) > 63) ? 6'd63 : 6'(el_reg);
            out_reg[13:8]  <= (int'(rem_reg) > 63) ? 6'd63 : 6'(rem_reg);
            out_reg[20:14] <= (int'(tot) > 127) ? 7'd127 : 7'(tot);
            out_reg[23:21] <= gait_reg;
        end
    end

    assign m_tdata = out_reg;

endmodule

/* hdl/gait_contact_scheduler_core.sv */
// top level of the gait contact scheduler
//  channel | dir | data fields (low bit up)
//  s_      | in  | target_gait, advance, query_row, query_leg
//  m_      | out | new_phase, contact, elapsed, remaining, duration, gait_now
// one item at a time; each item runs capture, fast-forward rolls (up to 4*STEPS),
// the advance roll if requested, scan init, the remaining scan (which may carry into
// the desired table), elapsed init, the elapsed scan (which may carry into the past
// table) and the result load; remaining and elapsed each reach at most about 2*STEPS
// reset clears the tables to their start patterns
// a held result stalls only the result load of the next item, in S_DONE
module gait_contact_scheduler_core import gcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // target_gait, advance, query_row, query_leg
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // new_phase, contact, elapsed_steps,
                                   // remaining_steps, duration_steps, gait_now
);

    gcs_cmd_t  cmd;
    gcs_stat_t stat;

    gcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gcs_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

/* hdl/gcs_checker.sv */
// port-level checks for the contact scheduler and their binding
module gcs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13:8] != 6'd0)
        else $error("remaining steps zero");

    a_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[20:14] == ({1'b0, m_tdata[7:2]} + {1'b0, m_tdata[13:8]}))
        else $error("duration is not elapsed plus remaining");

endmodule

bind gait_contact_scheduler_core gcs_checker u_gcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
